>>> hdl/curve25519_xz_diff_add_double_macros.svh
// Assertion macros for the Curve25519 X/Z differential add and double block.
// Used by the top level; depends on signals named clk and arst_n in scope.
`ifndef CURVE25519_XZ_DIFF_ADD_DOUBLE_MACROS_SVH
`define CURVE25519_XZ_DIFF_ADD_DOUBLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C25XZ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define C25XZ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/c25xz_pkg.sv
// Package for the Curve25519 X/Z differential add and double block.
// Holds item types, state encodings, the field program and constants; no dependencies.
`timescale 1ns / 1ps

package c25xz_pkg;

	localparam logic [16:0] A24_RESET   = 17'd121666;
	localparam logic [2:0]  SLOT_COUNT  = 3'd6;
	localparam int          OPND_DEPTH  = 24;
	localparam int          WORK_DEPTH  = 16;
	localparam int          RES_DEPTH   = 8;
	localparam int          LIMB_W      = 64;
	localparam int          FE_W        = 256;

	localparam logic [3:0] W_XD  = 4'd0;
	localparam logic [3:0] W_ZD  = 4'd1;
	localparam logic [3:0] W_XP  = 4'd2;
	localparam logic [3:0] W_ZP  = 4'd3;
	localparam logic [3:0] W_XQ  = 4'd4;
	localparam logic [3:0] W_ZQ  = 4'd5;
	localparam logic [3:0] W_A24 = 4'd6;
	localparam logic [3:0] W_T7  = 4'd7;
	localparam logic [3:0] W_T8  = 4'd8;
	localparam logic [3:0] W_T9  = 4'd9;
	localparam logic [3:0] W_T10 = 4'd10;
	localparam logic [3:0] W_T11 = 4'd11;
	localparam logic [3:0] W_T12 = 4'd12;
	localparam logic [3:0] W_T13 = 4'd13;
	localparam logic [3:0] W_T14 = 4'd14;
	localparam logic [3:0] W_T15 = 4'd15;

	localparam logic [4:0] PC_EQX     = 5'd0;
	localparam logic [4:0] PC_EQZ     = 5'd1;
	localparam logic [4:0] PC_DBL     = 5'd2;
	localparam logic [4:0] PC_DBL_END = 5'd10;
	localparam logic [4:0] PC_ADD     = 5'd11;
	localparam logic [4:0] PC_ADD_END = 5'd22;

	typedef struct packed {
		logic        operation;
		logic [2:0]  operand_slot;
		logic [1:0]  limb_index;
		logic [63:0] limb_value;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic        coordinate;
		logic [1:0]  out_limb_index;
		logic [63:0] out_limb_value;
		logic        out_last;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_CANON
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		logic zero;
		logic busy;
	} alu_sts_t;

	typedef struct packed {
		alu_op_t    op;
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] d;
	} instr_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_MUL,
		E_RED,
		E_FOLD,
		E_ADD,
		E_SUB,
		E_ADDP,
		E_CAN1,
		E_CAN2,
		E_FIN
	} alu_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_LDRD,
		T_LDSET,
		T_LDGO,
		T_LDWAIT,
		T_A24,
		T_FA,
		T_FB,
		T_FC,
		T_EXEC,
		T_CPA,
		T_CPB,
		T_CPC,
		T_CPW,
		T_OUT
	} top_state_t;

	function automatic instr_t mk(alu_op_t op, logic [3:0] a, logic [3:0] b, logic [3:0] d);
		instr_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		r.d = d;
		return r;
	endfunction

	// Equality checks, then the doubling, then the addition.
	function automatic instr_t prog(logic [4:0] pc);
		instr_t r;
		case (pc)
			5'd0:    r = mk(OP_SUB, W_XP, W_XQ, W_T7);
			5'd1:    r = mk(OP_SUB, W_ZP, W_ZQ, W_T7);
			5'd2:    r = mk(OP_ADD, W_XP, W_ZP, W_T7);
			5'd3:    r = mk(OP_SUB, W_XP, W_ZP, W_T8);
			5'd4:    r = mk(OP_MUL, W_T7, W_T7, W_T9);
			5'd5:    r = mk(OP_MUL, W_T8, W_T8, W_T10);
			5'd6:    r = mk(OP_SUB, W_T9, W_T10, W_T11);
			5'd7:    r = mk(OP_MUL, W_T9, W_T10, W_T12);
			5'd8:    r = mk(OP_MUL, W_A24, W_T11, W_T13);
			5'd9:    r = mk(OP_ADD, W_T10, W_T13, W_T14);
			5'd10:   r = mk(OP_MUL, W_T11, W_T14, W_T15);
			5'd11:   r = mk(OP_SUB, W_XQ, W_ZQ, W_T7);
			5'd12:   r = mk(OP_ADD, W_XP, W_ZP, W_T8);
			5'd13:   r = mk(OP_MUL, W_T7, W_T8, W_T9);
			5'd14:   r = mk(OP_ADD, W_XQ, W_ZQ, W_T10);
			5'd15:   r = mk(OP_SUB, W_XP, W_ZP, W_T11);
			5'd16:   r = mk(OP_MUL, W_T10, W_T11, W_T12);
			5'd17:   r = mk(OP_ADD, W_T9, W_T12, W_T13);
			5'd18:   r = mk(OP_SUB, W_T9, W_T12, W_T14);
			5'd19:   r = mk(OP_MUL, W_T13, W_T13, W_T7);
			5'd20:   r = mk(OP_MUL, W_T14, W_T14, W_T8);
			5'd21:   r = mk(OP_MUL, W_ZD, W_T7, W_T10);
			5'd22:   r = mk(OP_MUL, W_XD, W_T8, W_T11);
			default: r = mk(OP_ADD, W_T7, W_T7, W_T7);
		endcase
		return r;
	endfunction

	function automatic logic [31:0] p_word(logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0:    r = 32'hFFFFFFED;
			3'd7:    r = 32'h7FFFFFFF;
			default: r = 32'hFFFFFFFF;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/c25xz_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the operand, work and result stores.
`timescale 1ns / 1ps

module c25xz_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 24,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/c25xz_fe_alu.sv
// Word-serial arithmetic unit mod 2^255-19 around one 32x32 multiplier.
// Depends on c25xz_pkg for the command, status and state types.
`timescale 1ns / 1ps

module c25xz_fe_alu import c25xz_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  alu_cmd_t     cmd,
	input  logic [255:0] a,
	input  logic [255:0] b,
	output alu_sts_t     sts,
	output logic [255:0] r
);

	alu_state_t   est_q, est_d;
	logic [2:0]   i_q, i_d, j_q, j_d;
	logic         k_q, k_d;
	logic [31:0]  carry_q, carry_d;
	logic [255:0] a_q, a_d, b_q, b_d, r_q, r_d, t_q, t_d;
	logic [511:0] prod_q, prod_d;
	logic [7:0]   ws, wsj;
	logic [3:0]   idx, idx8;
	logic [31:0]  aw, bw, bjw, rw;
	logic [63:0]  mprod, acc, cin;
	logic [32:0]  diff;

	assign ws   = {i_q, 5'd0};
	assign wsj  = {j_q, 5'd0};
	assign idx  = {1'b0, i_q} + {1'b0, j_q};
	assign idx8 = {1'b0, i_q} + 4'd8;
	assign aw   = a_q[ws +: 32];
	assign bw   = b_q[ws +: 32];
	assign bjw  = b_q[wsj +: 32];
	assign rw   = r_q[ws +: 32];
	assign mprod = aw * bjw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q   <= E_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= 1'b0;
			carry_q <= '0;
		end else begin
			est_q   <= est_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			carry_q <= carry_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q    <= a_d;
		b_q    <= b_d;
		r_q    <= r_d;
		t_q    <= t_d;
		prod_q <= prod_d;
	end

	always_comb begin
		est_d   = est_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		carry_d = carry_q;
		a_d     = a_q;
		b_d     = b_q;
		r_d     = r_q;
		t_d     = t_q;
		prod_d  = prod_q;
		acc     = '0;
		cin     = '0;
		diff    = '0;
		case (est_q)
			E_IDLE: begin
				if (cmd.start) begin
					a_d = a;
					b_d = b;
					i_d = '0;
					j_d = '0;
					k_d = 1'b0;
					carry_d = '0;
					case (cmd.op)
						OP_MUL: begin
							prod_d = '0;
							est_d = E_MUL;
						end
						OP_ADD: est_d = E_ADD;
						OP_SUB: est_d = E_SUB;
						OP_CANON: begin
							r_d = a;
							est_d = E_CAN1;
						end
						default: est_d = E_IDLE;
					endcase
				end
			end
			E_MUL: begin
				acc = mprod + {32'd0, prod_q[{idx, 5'd0} +: 32]} + {32'd0, carry_q};
				prod_d[{idx, 5'd0} +: 32] = acc[31:0];
				carry_d = acc[63:32];
				j_d = j_q + 3'd1;
				if (j_q == 3'd7) begin
					prod_d[{idx8, 5'd0} +: 32] = acc[63:32];
					carry_d = '0;
					i_d = i_q + 3'd1;
					if (i_q == 3'd7) begin
						est_d = E_RED;
					end
				end
			end
			E_RED: begin
				acc = {32'd0, prod_q[{1'b0, i_q, 5'd0} +: 32]}
					+ {32'd0, prod_q[{idx8, 5'd0} +: 32]} * 64'd38 + {32'd0, carry_q};
				r_d[ws +: 32] = acc[31:0];
				carry_d = acc[63:32];
				i_d = i_q + 3'd1;
				if (i_q == 3'd7) begin
					k_d = 1'b0;
					est_d = E_FOLD;
				end
			end
			E_FOLD: begin
				cin = (i_q == 3'd0) ? {32'd0, carry_q} * 64'd38 : {32'd0, carry_q};
				acc = cin + {32'd0, rw};
				r_d[ws +: 32] = acc[31:0];
				carry_d = acc[63:32];
				i_d = i_q + 3'd1;
				if (i_q == 3'd7) begin
					k_d = 1'b1;
					if (k_q) begin
						carry_d = '0;
						est_d = E_CAN1;
					end
				end
			end
			E_ADD: begin
				acc = {32'd0, aw} + {32'd0, bw} + {32'd0, carry_q};
				r_d[ws +: 32] = acc[31:0];
				carry_d = acc[63:32];
				i_d = i_q + 3'd1;
				if (i_q == 3'd7) begin
					carry_d = '0;
					est_d = E_CAN1;
				end
			end
			E_SUB: begin
				diff = {1'b0, aw} - {1'b0, bw} - {32'd0, carry_q[0]};
				r_d[ws +: 32] = diff[31:0];
				carry_d = {31'd0, diff[32]};
				i_d = i_q + 3'd1;
				if (i_q == 3'd7) begin
					carry_d = '0;
					est_d = diff[32] ? E_ADDP : E_CAN1;
				end
			end
			E_ADDP: begin
				acc = {32'd0, rw} + {32'd0, p_word(i_q)} + {32'd0, carry_q};
				r_d[ws +: 32] = acc[31:0];
				carry_d = acc[63:32];
				i_d = i_q + 3'd1;
				if (i_q == 3'd7) begin
					carry_d = '0;
					est_d = E_CAN1;
				end
			end
			E_CAN1: begin
				cin = (i_q == 3'd0) ? (r_q[255] ? 64'd19 : 64'd0) : {32'd0, carry_q};
				acc = cin + {32'd0, (i_q == 3'd7) ? {1'b0, rw[30:0]} : rw};
				r_d[ws +: 32] = acc[31:0];
				carry_d = acc[63:32];
				i_d = i_q + 3'd1;
				if (i_q == 3'd7) begin
					carry_d = '0;
					est_d = E_CAN2;
				end
			end
			E_CAN2: begin
				cin = (i_q == 3'd0) ? 64'd19 : {32'd0, carry_q};
				acc = cin + {32'd0, rw};
				t_d[ws +: 32] = acc[31:0];
				carry_d = acc[63:32];
				i_d = i_q + 3'd1;
				if (i_q == 3'd7) begin
					carry_d = '0;
					est_d = E_FIN;
				end
			end
			E_FIN: est_d = E_IDLE;
			default: est_d = E_IDLE;
		endcase
	end

	assign r        = t_q[255] ? {1'b0, t_q[254:0]} : r_q;
	assign sts.done = (est_q == E_FIN);
	assign sts.zero = (r == '0);
	assign sts.busy = (est_q != E_IDLE);

endmodule

>>> hdl/curve25519_xz_diff_add_double.sv
// Top level of the Curve25519 X/Z differential add and double block.
// Depends on c25xz_pkg, c25xz_ram, c25xz_fe_alu and the assertion macro header.
`timescale 1ns / 1ps
`include "curve25519_xz_diff_add_double_macros.svh"

// Input items load 64-bit limbs of six operands into the operand store; an item
// with last set also starts the operation it names. After reset the curve
// constant is 121666, no operation runs and both channels are idle.
// While idle the block takes load items without stalling. After the starting
// item the block reads and reduces the six operands, runs the field program on
// one word-serial unit and then streams eight result items, X limbs 0 to 3
// and then Z limbs 0 to 3. Results leave the result store one at a time: a
// new read is issued only once the output register is empty, and a stall
// holds the output register and the result store read. During result output
// the block keeps taking load items; after a starting item it stalls the
// input until the eighth result has been taken. Configuration is written
// with cfg_we while idle.

module curve25519_xz_diff_add_double import c25xz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);

	top_state_t   state_q, state_d;
	logic [2:0]   slot_q;
	logic [1:0]   limb_q;
	logic         ld_v_s1;
	logic [1:0]   ld_limb_s1;
	logic [255:0] raw_q, opa_q;
	logic [511:0] cp_q;
	logic [4:0]   pc_q, pc_d;
	logic [5:0]   zf_q;
	logic         eqx_q, op_q, go_q;
	logic [3:0]   cpx_q, cpx_d, cpz_q, cpz_d;
	logic [2:0]   k_q;
	logic [3:0]   oc_q;
	logic         orr_s1;
	logic [2:0]   oidx_s1;
	logic         out_v_q;
	out_item_t    out_item_q;
	logic [16:0]  a24_q;

	logic         in_acc, out_acc, issue_rd;
	logic         op_we;
	logic [4:0]   op_waddr, op_raddr;
	logic [63:0]  op_rdata;
	logic         w_we;
	logic [3:0]   w_waddr, w_raddr;
	logic [255:0] w_wdata, w_rdata;
	logic         r_we;
	logic [2:0]   r_waddr, r_raddr;
	logic [63:0]  r_wdata, r_rdata;
	instr_t       ins;
	alu_cmd_t     cmd;
	alu_sts_t     sts;
	logic [255:0] alu_a, alu_b, alu_r;
	logic         id_p, id_q;

	assign in_stall = !(state_q == T_IDLE || (state_q == T_OUT && !go_q));
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_v_q && !out_stall;
	assign ins      = prog(pc_q);
	assign id_p     = zf_q[2] && zf_q[3];
	assign id_q     = zf_q[4] && zf_q[5];

	assign op_we    = in_acc && (in_item.operand_slot < SLOT_COUNT);
	assign op_waddr = {in_item.operand_slot, in_item.limb_index};
	assign op_raddr = {slot_q, limb_q};
	assign r_waddr  = k_q;
	assign r_wdata  = cp_q[{k_q, 6'd0} +: 64];
	assign r_raddr  = oc_q[2:0];

	c25xz_ram #(.WIDTH(LIMB_W), .DEPTH(OPND_DEPTH)) u_opnd (
		.clk(clk), .we(op_we), .waddr(op_waddr), .wdata(in_item.limb_value),
		.raddr(op_raddr), .rdata(op_rdata)
	);

	c25xz_ram #(.WIDTH(FE_W), .DEPTH(WORK_DEPTH)) u_work (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	c25xz_ram #(.WIDTH(LIMB_W), .DEPTH(RES_DEPTH)) u_res (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	c25xz_fe_alu u_alu (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .a(alu_a), .b(alu_b),
		.sts(sts), .r(alu_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		cpx_d    = cpx_q;
		cpz_d    = cpz_q;
		w_we     = 1'b0;
		w_waddr  = ins.d;
		w_wdata  = alu_r;
		w_raddr  = ins.a;
		r_we     = 1'b0;
		cmd      = '{start: 1'b0, op: OP_CANON};
		alu_a    = raw_q;
		alu_b    = w_rdata;
		issue_rd = 1'b0;
		case (state_q)
			T_IDLE: begin
				if (in_acc && in_item.last) begin
					state_d = T_LDRD;
				end
			end
			T_LDRD: begin
				if (limb_q == 2'd3) begin
					state_d = T_LDSET;
				end
			end
			T_LDSET: state_d = T_LDGO;
			T_LDGO: begin
				cmd = '{start: 1'b1, op: OP_CANON};
				state_d = T_LDWAIT;
			end
			T_LDWAIT: begin
				w_waddr = {1'b0, slot_q};
				if (sts.done) begin
					w_we = 1'b1;
					state_d = (slot_q == 3'd5) ? T_A24 : T_LDRD;
				end
			end
			T_A24: begin
				w_we = 1'b1;
				w_waddr = W_A24;
				w_wdata = {239'd0, a24_q};
				pc_d = PC_EQX;
				state_d = T_FA;
			end
			T_FA: begin
				w_raddr = ins.a;
				state_d = T_FB;
			end
			T_FB: begin
				w_raddr = ins.b;
				state_d = T_FC;
			end
			T_FC: begin
				cmd = '{start: 1'b1, op: ins.op};
				alu_a = opa_q;
				state_d = T_EXEC;
			end
			T_EXEC: begin
				if (sts.done) begin
					w_we = 1'b1;
					pc_d = pc_q + 5'd1;
					state_d = T_FA;
					if (pc_q == PC_EQZ) begin
						if (!op_q) begin
							if (id_p) begin
								cpx_d = W_XP;
								cpz_d = W_ZP;
								state_d = T_CPA;
							end else begin
								pc_d = PC_DBL;
							end
						end else if (id_q) begin
							cpx_d = W_XP;
							cpz_d = W_ZP;
							state_d = T_CPA;
						end else if (id_p) begin
							cpx_d = W_XQ;
							cpz_d = W_ZQ;
							state_d = T_CPA;
						end else if (eqx_q && sts.zero) begin
							pc_d = PC_DBL;
						end else begin
							pc_d = PC_ADD;
						end
					end else if (pc_q == PC_DBL_END) begin
						cpx_d = W_T12;
						cpz_d = W_T15;
						state_d = T_CPA;
					end else if (pc_q == PC_ADD_END) begin
						cpx_d = W_T10;
						cpz_d = W_T11;
						state_d = T_CPA;
					end
				end
			end
			T_CPA: begin
				w_raddr = cpx_q;
				state_d = T_CPB;
			end
			T_CPB: begin
				w_raddr = cpz_q;
				state_d = T_CPC;
			end
			T_CPC: state_d = T_CPW;
			T_CPW: begin
				r_we = 1'b1;
				if (k_q == 3'd7) begin
					state_d = T_OUT;
				end
			end
			T_OUT: begin
				issue_rd = !orr_s1 && !out_v_q && !oc_q[3];
				if (out_acc && out_item_q.out_last) begin
					state_d = (go_q || (in_acc && in_item.last)) ? T_LDRD : T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			limb_q  <= '0;
			pc_q    <= '0;
			k_q     <= '0;
			oc_q    <= '0;
			ld_v_s1 <= 1'b0;
			orr_s1  <= 1'b0;
			out_v_q <= 1'b0;
			go_q    <= 1'b0;
			op_q    <= 1'b0;
			zf_q    <= '0;
			eqx_q   <= 1'b0;
			cpx_q   <= '0;
			cpz_q   <= '0;
			a24_q   <= A24_RESET;
		end else begin
			pc_q    <= pc_d;
			cpx_q   <= cpx_d;
			cpz_q   <= cpz_d;
			ld_v_s1 <= (state_q == T_LDRD);
			orr_s1  <= issue_rd;
			if (cfg_we) begin
				a24_q <= cfg_wdata;
			end
			if (in_acc && in_item.last) begin
				op_q <= in_item.operation;
			end
			if (state_d == T_LDRD && (state_q == T_IDLE || state_q == T_OUT)) begin
				slot_q <= '0;
				limb_q <= '0;
				go_q   <= 1'b0;
			end else begin
				if (in_acc && in_item.last && state_q == T_OUT) begin
					go_q <= 1'b1;
				end
				if (state_q == T_LDRD) begin
					limb_q <= limb_q + 2'd1;
				end else if (state_q == T_LDWAIT && sts.done) begin
					zf_q[slot_q] <= sts.zero;
					slot_q <= slot_q + 3'd1;
					limb_q <= '0;
				end
			end
			if (state_q == T_EXEC && sts.done && pc_q == PC_EQX) begin
				eqx_q <= sts.zero;
			end
			if (state_q == T_CPC) begin
				k_q <= '0;
			end else if (state_q == T_CPW) begin
				k_q <= k_q + 3'd1;
			end
			if (state_q == T_CPW) begin
				oc_q <= '0;
			end else if (issue_rd) begin
				oc_q <= oc_q + 4'd1;
			end
			if (orr_s1) begin
				out_v_q <= 1'b1;
			end else if (out_acc) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ld_limb_s1 <= limb_q;
		oidx_s1    <= oc_q[2:0];
		if (ld_v_s1) begin
			raw_q[{ld_limb_s1, 6'd0} +: 64] <= op_rdata;
		end
		if (state_q == T_FB) begin
			opa_q <= w_rdata;
		end
		if (state_q == T_CPB) begin
			cp_q[255:0] <= w_rdata;
		end
		if (state_q == T_CPC) begin
			cp_q[511:256] <= w_rdata;
		end
		if (orr_s1) begin
			out_item_q.coordinate     <= oidx_s1[2];
			out_item_q.out_limb_index <= oidx_s1[1:0];
			out_item_q.out_limb_value <= r_rdata;
			out_item_q.out_last       <= (oidx_s1 == 3'd7);
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_item_q;

	`C25XZ_ASSERT_IMP(a_alu_start_idle, cmd.start, !sts.busy,
		"field unit started while busy")
	`C25XZ_ASSERT_IMP(a_in_only_idle, in_valid && !in_stall,
		state_q == T_IDLE || state_q == T_OUT, "item taken while computing")
	`C25XZ_ASSERT_IMP(a_done_expected, sts.done,
		state_q == T_LDWAIT || state_q == T_EXEC, "field result with no consumer")
	`C25XZ_ASSERT_NXT(a_out_from_read, orr_s1, out_valid,
		"result store read did not fill the output register")

endmodule

>>> bench/testbench.sv
// Self-checking testbench for the Curve25519 X/Z differential add and double block.
// Depends on c25xz_pkg and curve25519_xz_diff_add_double; field arithmetic is predicted locally.
`timescale 1ns / 1ps

module testbench;
	import c25xz_pkg::*;

	localparam logic [255:0] PRIME = (256'd1 << 255) - 256'd19;
	localparam logic [63:0] ONES = 64'hFFFFFFFFFFFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [16:0] cfg_wdata = '0;

	in_item_t pending[$];
	out_item_t expected_limbs[$];
	logic [63:0] operand_limbs[24];
	logic [16:0] a24_value = A24_RESET;
	int mismatches = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit quiet = 1'b0;

	curve25519_xz_diff_add_double DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [255:0] fe_reduce(logic [511:0] x);
		while (x >= (512'd1 << 255))
			x = (x & ((512'd1 << 255) - 1)) + (x >> 255) * 19;
		if (x >= PRIME)
			x = x - PRIME;
		return x[255:0];
	endfunction

	function automatic logic [255:0] fe_add(logic [255:0] a, logic [255:0] b);
		return fe_reduce({256'd0, a} + {256'd0, b});
	endfunction

	function automatic logic [255:0] fe_sub(logic [255:0] a, logic [255:0] b);
		return (a >= b) ? a - b : a + PRIME - b;
	endfunction

	function automatic logic [255:0] fe_mul(logic [255:0] a, logic [255:0] b);
		logic [511:0] prod;
		prod = {256'd0, a} * {256'd0, b};
		return fe_reduce(prod);
	endfunction

	function automatic void point_double(input logic [255:0] x, input logic [255:0] z,
			output logic [255:0] rx, output logic [255:0] rz);
		logic [255:0] aa, bb, cc;
		if (x == 0 && z == 0) begin
			rx = '0;
			rz = '0;
			return;
		end
		aa = fe_mul(fe_add(x, z), fe_add(x, z));
		bb = fe_mul(fe_sub(x, z), fe_sub(x, z));
		cc = fe_sub(aa, bb);
		rx = fe_mul(aa, bb);
		rz = fe_mul(cc, fe_add(bb, fe_mul({239'd0, a24_value}, cc)));
	endfunction

	function automatic logic [255:0] operand_value(int slot);
		return fe_reduce({256'd0, operand_limbs[slot * 4 + 3], operand_limbs[slot * 4 + 2],
			operand_limbs[slot * 4 + 1], operand_limbs[slot * 4]});
	endfunction

	task automatic predict_ladder_step(in_item_t it);
		logic [255:0] xd, zd, xp, zp, xq, zq, rx, rz, da, cb, s, d;
		out_item_t o;
		if (it.operand_slot < SLOT_COUNT)
			operand_limbs[it.operand_slot * 4 + it.limb_index] = it.limb_value;
		if (!it.last)
			return;
		xd = operand_value(0);
		zd = operand_value(1);
		xp = operand_value(2);
		zp = operand_value(3);
		xq = operand_value(4);
		zq = operand_value(5);
		if (!it.operation)
			point_double(xp, zp, rx, rz);
		else if (xq == 0 && zq == 0) begin
			rx = xp;
			rz = zp;
		end else if (xp == 0 && zp == 0) begin
			rx = xq;
			rz = zq;
		end else if (xp == xq && zp == zq)
			point_double(xp, zp, rx, rz);
		else begin
			da = fe_mul(fe_sub(xq, zq), fe_add(xp, zp));
			cb = fe_mul(fe_add(xq, zq), fe_sub(xp, zp));
			s = fe_add(da, cb);
			d = fe_sub(da, cb);
			rx = fe_mul(zd, fe_mul(s, s));
			rz = fe_mul(xd, fe_mul(d, d));
		end
		for (int k = 0; k < 8; k++) begin
			o.coordinate = k[2];
			o.out_limb_index = k[1:0];
			o.out_limb_value = k[2] ? rz[k[1:0] * 64 +: 64] : rx[k[1:0] * 64 +: 64];
			o.out_last = (k == 7);
			expected_limbs.insert(expected_limbs.size(), o);
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_ladder_step(in_item);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					in_item <= pending.pop_front();
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_limbs.size() == 0) begin
					report_mismatch("unexpected item", out_item.out_limb_value, 64'd0);
				end else begin
					want = expected_limbs.pop_front();
					if (out_item.coordinate !== want.coordinate)
						report_mismatch("coordinate", 64'(out_item.coordinate),
							64'(want.coordinate));
					if (out_item.out_limb_index !== want.out_limb_index)
						report_mismatch("limb index", 64'(out_item.out_limb_index),
							64'(want.out_limb_index));
					if (out_item.out_limb_value !== want.out_limb_value)
						report_mismatch("limb value", out_item.out_limb_value,
							want.out_limb_value);
					if (out_item.out_last !== want.out_last)
						report_mismatch("last flag", 64'(out_item.out_last),
							64'(want.out_last));
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				recv_gap <= $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [63:0] random_limb();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return ONES;
			2: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic put(logic op, logic [2:0] slot, logic [1:0] li, logic [63:0] v, logic lst);
		in_item_t it;
		it.operation = op;
		it.operand_slot = slot;
		it.limb_index = li;
		it.limb_value = v;
		it.last = lst;
		pending.insert(pending.size(), it);
	endtask

	task automatic put_coord(logic [2:0] slot, logic [255:0] v);
		for (int i = 0; i < 4; i++)
			put(1'($urandom_range(0, 1)), slot, 2'(i), v[i * 64 +: 64], 1'b0);
	endtask

	function automatic logic [255:0] random_coord();
		return {random_limb(), random_limb(), random_limb(), random_limb()};
	endfunction

	task automatic random_sequence();
		logic [255:0] px, pz;
		logic op;
		op = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				for (int s = 0; s < 6; s++)
					if ($urandom_range(0, 1))
						put_coord(3'(s), random_coord());
			end
			4: begin
				px = random_coord();
				pz = random_coord();
				put_coord(3'd2, px);
				put_coord(3'd3, pz);
				put_coord(3'd4, px);
				put_coord(3'd5, pz);
			end
			5: begin
				put_coord($urandom_range(0, 1) ? 3'd2 : 3'd4, 256'd0);
				put_coord($urandom_range(0, 1) ? 3'd3 : 3'd5, 256'd0);
			end
			6: begin
				put(1'($urandom_range(0, 1)), 3'($urandom_range(6, 7)),
					2'($urandom_range(0, 3)), random_limb(), 1'b0);
			end
			default: begin
				for (int n = $urandom_range(1, 3); n > 0; n--)
					put(1'($urandom_range(0, 1)), 3'($urandom_range(0, 5)),
						2'($urandom_range(0, 3)), random_limb(), 1'b0);
			end
		endcase
		put(op, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), random_limb(), 1'b1);
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_limbs.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_a24(logic [16:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		a24_value = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(logic [16:0] a24, int count);
		int n0;
		write_a24(a24);
		@(negedge clk);
		while (count > 0) begin
			n0 = pending.size();
			random_sequence();
			count -= pending.size() - n0;
		end
		drain();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Fill every operand limb before the first operation.
		for (int s = 0; s < 6; s++)
			put_coord(3'(s), random_coord());
		put(1'b0, 3'd2, 2'd0, ONES, 1'b1);
		put_coord(3'd2, {ONES, ONES, ONES, ONES});
		put(1'b1, 3'd3, 2'd3, ONES, 1'b1);
		put_coord(3'd2, PRIME);
		put_coord(3'd3, 256'd0);
		put(1'b0, 3'd7, 2'd1, ONES, 1'b1);
		put(1'b1, 3'd6, 2'd2, 64'd0, 1'b1);
		put_coord(3'd2, 256'd9);
		put(1'b1, 3'd3, 2'd0, 64'd1, 1'b1);
		put(1'b1, 3'd4, 2'd0, 64'd9, 1'b1);
		drain();
		random_phase(17'd0, 25);
		random_phase(17'h1FFFF, 25);
		random_phase(17'($urandom_range(0, 17'h1FFFF)), 25);
		quiet = 1'b1;
		random_phase(A24_RESET, 25);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/c25xz_pkg.sv
hdl/c25xz_ram.sv
hdl/c25xz_fe_alu.sv
hdl/curve25519_xz_diff_add_double.sv
bench/testbench.sv
